@@ hw/rtl/dcs_pkg.sv @@
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared constants and controller/datapath interface types for the
// delimiter character stuffer.
// ----------------------------------------------------------------------------
`default_nettype none

package dcs_pkg;

    // default window depth and longest delimiter
    localparam int MAX_DELIM_DEF = 8;

    // configuration port
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_DELIM_LENGTH = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DELIM_BYTES  = 4'd1;

    // register reset values
    localparam logic [3:0]            DELIM_LENGTH_RST = 4'd1;
    localparam logic [CFG_DATA_W-1:0] DELIM_BYTES_RST  = 64'd126;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;      // take the input request into the window
        logic emit_delim;  // load output with delimiter byte k
        logic emit_win;    // load output with oldest window byte
        logic emit_last;   // run_last flag of the loaded result
        logic emit_done;   // frame_done flag of the loaded result
        logic shift_one;   // drop the oldest window byte
        logic shift_len;   // drop a delimiter length of window bytes
        logic k_clr;       // restart delimiter byte index
        logic k_inc;       // advance delimiter byte index
        logic rep_set;     // second delimiter copy of a match follows
        logic rep_clr;
        logic frame_end;   // empty the window and leave the frame
    } dcs_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic in_frame;
        logic last;        // current request closes the frame
        logic out_free;    // output register can take a result
        logic cnt_ge_len;
        logic cnt_le_len;
        logic cnt_lt_2len;
        logic cnt_is_one;
        logic cnt_zero;
        logic match;       // window head equals the delimiter
        logic k_end;       // index is at the last delimiter byte
        logic rep;
    } dcs_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/delimiter_char_stuffer.sv @@
// Sequence: a request is accepted in the idle state; the opener or the window compare
// then loads the output register, or a window match first starts a doubled delimiter.
// Throughput: one output byte per cycle while the sequencer emits and the output is
// free; a plain payload byte passes accept and window compare, each opener, doubled
// or closing delimiter byte adds an emit step, a window match one more compare step.
// Reset: aresetn synchronous active low; length 1, delimiter 0x7e, no frame, window empty.
// ----------------------------------------------------------------------------
// delimiter_char_stuffer
// Frames a byte stream with a configurable 1 to 8 byte delimiter, doubling
// any in-band delimiter occurrence found in the look-ahead window.
// ----------------------------------------------------------------------------
`default_nettype none

module delimiter_char_stuffer #(
    parameter int MAX_DELIM = dcs_pkg::MAX_DELIM_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration writes
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [dcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dcs_pkg::CFG_DATA_W-1:0] cfg_data,
    // input requests
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [7:0]                     s_data_byte,
    input  wire logic                           s_frame_last,
    // stuffed stream
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [7:0]                          m_out_byte,
    output logic                                m_frame_done,
    output logic                                m_run_last
);

    dcs_pkg::dcs_cmd_t cmd;
    dcs_pkg::dcs_sts_t sts;

    assign cfg_ready = 1'b1;

    // sequencer
    dcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // window and output datapath
    dcs_dp #(
        .MAX_DELIM (MAX_DELIM)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_data_byte  (s_data_byte),
        .s_frame_last (s_frame_last),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_out_byte   (m_out_byte),
        .m_frame_done (m_frame_done),
        .m_run_last   (m_run_last),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

`default_nettype wire

@@ hw/rtl/dcs_ctrl.sv @@
// ----------------------------------------------------------------------------
// dcs_ctrl
// Sequencer of the stuffer: opener, window compare, doubled delimiter,
// tail drain and closing delimiter, at most one output byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire dcs_pkg::dcs_sts_t sts,
    output dcs_pkg::dcs_cmd_t     cmd
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_OPEN  = 6'b000010,
        ST_EVAL  = 6'b000100,
        ST_DBL   = 6'b001000,
        ST_TAIL  = 6'b010000,
        ST_CLOSE = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // next state and datapath commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    cmd.k_clr  = 1'b1;
                    state_next = sts.in_frame ? ST_EVAL : ST_OPEN;
                end
            end
            ST_OPEN: begin
                if (sts.out_free) begin
                    cmd.emit_delim = 1'b1;
                    cmd.emit_last  = sts.k_end && !sts.last && !sts.cnt_ge_len;
                    cmd.k_inc      = 1'b1;
                    if (sts.k_end) begin
                        cmd.k_clr  = 1'b1;
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                if (sts.cnt_ge_len && sts.match) begin
                    cmd.k_clr   = 1'b1;
                    cmd.rep_clr = 1'b1;
                    state_next  = ST_DBL;
                end else if (sts.cnt_ge_len) begin
                    if (sts.out_free) begin
                        cmd.emit_win  = 1'b1;
                        cmd.emit_last = sts.cnt_le_len && !sts.last;
                        cmd.shift_one = 1'b1;
                        if (sts.cnt_le_len && !sts.last) begin
                            state_next = ST_IDLE;
                        end
                    end
                end else if (sts.last) begin
                    cmd.k_clr  = 1'b1;
                    state_next = sts.cnt_zero ? ST_CLOSE : ST_TAIL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DBL: begin
                if (sts.out_free) begin
                    cmd.emit_delim = 1'b1;
                    cmd.emit_last  = sts.rep && sts.k_end && !sts.last && sts.cnt_lt_2len;
                    cmd.k_inc      = 1'b1;
                    if (sts.k_end) begin
                        cmd.k_clr = 1'b1;
                        if (sts.rep) begin
                            cmd.shift_len = 1'b1;
                            state_next    = ST_EVAL;
                        end else begin
                            cmd.rep_set = 1'b1;
                        end
                    end
                end
            end
            ST_TAIL: begin
                if (sts.out_free) begin
                    cmd.emit_win  = 1'b1;
                    cmd.shift_one = 1'b1;
                    if (sts.cnt_is_one) begin
                        cmd.k_clr  = 1'b1;
                        state_next = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE: begin
                if (sts.out_free) begin
                    cmd.emit_delim = 1'b1;
                    cmd.emit_done  = sts.k_end;
                    cmd.emit_last  = sts.k_end;
                    cmd.k_inc      = 1'b1;
                    if (sts.k_end) begin
                        cmd.frame_end = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/dcs_dp.sv @@
// ----------------------------------------------------------------------------
// dcs_dp
// Datapath of the stuffer: configuration registers, look-ahead window,
// delimiter byte index, window compare and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_dp #(
    parameter int MAX_DELIM = dcs_pkg::MAX_DELIM_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    input  wire logic [dcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dcs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [7:0]                     s_data_byte,
    input  wire logic                           s_frame_last,
    input  wire logic                           m_ready,
    output logic                                m_valid,
    output logic [7:0]                          m_out_byte,
    output logic                                m_frame_done,
    output logic                                m_run_last,
    input  wire dcs_pkg::dcs_cmd_t              cmd,
    output dcs_pkg::dcs_sts_t                   sts
);

    localparam int CW = $clog2(MAX_DELIM + 1);
    localparam int KW = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;

    logic [3:0]                     delim_length_reg;
    logic [dcs_pkg::CFG_DATA_W-1:0] delim_bytes_reg;
    logic [7:0]                     win_reg [MAX_DELIM];
    logic [7:0]                     win_next [MAX_DELIM];
    logic [CW-1:0]                  cnt_reg;
    logic [CW-1:0]                  cnt_next;
    logic                           in_frame_reg;
    logic                           last_reg;
    logic [CW-1:0]                  len_reg;
    logic [KW-1:0]                  k_reg;
    logic                           rep_reg;
    logic                           m_valid_reg;
    logic [7:0]                     out_byte_reg;
    logic                           frame_done_reg;
    logic                           run_last_reg;
    logic [CW-1:0]                  len_eff;
    logic [7:0]                     delim_k;
    logic                           match;
    logic                           out_free;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_length_reg <= dcs_pkg::DELIM_LENGTH_RST;
            delim_bytes_reg  <= dcs_pkg::DELIM_BYTES_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                dcs_pkg::REG_DELIM_LENGTH: delim_length_reg <= cfg_data[3:0];
                dcs_pkg::REG_DELIM_BYTES:  delim_bytes_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // saturated delimiter length
    always_comb begin
        if (delim_length_reg == 4'd0) begin
            len_eff = CW'(1);
        end else if (delim_length_reg > 4'(MAX_DELIM)) begin
            len_eff = CW'(MAX_DELIM);
        end else begin
            len_eff = delim_length_reg[CW-1:0];
        end
    end

    assign delim_k = delim_bytes_reg[{k_reg, 3'b000} +: 8];

    // window head against delimiter, bytes past the length ignored
    always_comb begin
        match = 1'b1;
        for (int i = 0; i < MAX_DELIM; i++) begin
            if ((CW'(i) < len_reg) && (win_reg[i] != delim_bytes_reg[8*i +: 8])) begin
                match = 1'b0;
            end
        end
    end

    // window and fill count update
    always_comb begin
        win_next = win_reg;
        cnt_next = cnt_reg;
        if (cmd.accept) begin
            if (!in_frame_reg) begin
                win_next[0] = s_data_byte;
                cnt_next    = CW'(1);
            end else if (cnt_reg < CW'(MAX_DELIM)) begin
                for (int i = 0; i < MAX_DELIM; i++) begin
                    if (CW'(i) == cnt_reg) begin
                        win_next[i] = s_data_byte;
                    end
                end
                cnt_next = cnt_reg + CW'(1);
            end
        end else if (cmd.shift_one) begin
            for (int i = 0; i < MAX_DELIM - 1; i++) begin
                win_next[i] = win_reg[i + 1];
            end
            cnt_next = cnt_reg - CW'(1);
        end else if (cmd.shift_len) begin
            for (int i = 0; i < MAX_DELIM; i++) begin
                for (int j = 0; j < MAX_DELIM; j++) begin
                    if ((CW + 1)'(j) == (CW + 1)'(i) + {1'b0, len_reg}) begin
                        win_next[i] = win_reg[j];
                    end
                end
            end
            cnt_next = cnt_reg - len_reg;
        end else if (cmd.frame_end) begin
            cnt_next = '0;
        end
    end

    // window storage
    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    // frame control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            in_frame_reg <= 1'b0;
            last_reg     <= 1'b0;
            len_reg      <= CW'(1);
            k_reg        <= '0;
            rep_reg      <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (cmd.accept) begin
                in_frame_reg <= 1'b1;
                last_reg     <= s_frame_last;
                len_reg      <= len_eff;
            end else if (cmd.frame_end) begin
                in_frame_reg <= 1'b0;
            end
            if (cmd.k_clr) begin
                k_reg <= '0;
            end else if (cmd.k_inc) begin
                k_reg <= k_reg + KW'(1);
            end
            if (cmd.rep_clr) begin
                rep_reg <= 1'b0;
            end else if (cmd.rep_set) begin
                rep_reg <= 1'b1;
            end
        end
    end

    // output register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit_delim || cmd.emit_win) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_delim || cmd.emit_win) begin
            out_byte_reg   <= cmd.emit_delim ? delim_k : win_reg[0];
            frame_done_reg <= cmd.emit_done;
            run_last_reg   <= cmd.emit_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = out_byte_reg;
    assign m_frame_done = frame_done_reg;
    assign m_run_last   = run_last_reg;

    // status to controller
    always_comb begin
        sts             = '0;
        sts.in_frame    = in_frame_reg;
        sts.last        = last_reg;
        sts.out_free    = out_free;
        sts.cnt_ge_len  = (cnt_reg >= len_reg);
        sts.cnt_le_len  = (cnt_reg <= len_reg);
        sts.cnt_lt_2len = ({1'b0, cnt_reg} < {len_reg, 1'b0});
        sts.cnt_is_one  = (cnt_reg == CW'(1));
        sts.cnt_zero    = (cnt_reg == '0);
        sts.match       = match;
        sts.k_end       = ((CW + 1)'(k_reg) + (CW + 1)'(1) == {1'b0, len_reg});
        sts.rep         = rep_reg;
    end

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_delim || cmd.emit_win) |-> out_free)
        else $error("result loaded while output register is held");

    // window never holds more than the maximum delimiter length
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_DELIM))
        else $error("window fill count out of range");

    // closing delimiter leaves an empty window outside any frame
    a_frame_end: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.frame_end |=> (!in_frame_reg && cnt_reg == '0))
        else $error("frame end did not clear window state");

    // closing byte of a frame is always the last result of its request
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_done) |-> m_run_last)
        else $error("frame_done without run_last");

endmodule

`default_nettype wire

@@ dv/stuffed_stream_checker.sv @@
// ----------------------------------------------------------------------------
// stuffed_stream_checker
// Watches the register, input and stuffed-stream channels of the delimiter
// character stuffer. It keeps its own copy of the window and delimiter
// registers, works out the stuffed bytes of each accepted input byte, and
// compares every accepted output byte against the oldest expected one.
// ----------------------------------------------------------------------------
module stuffed_stream_checker #(
    parameter int MAX_DELIM = dcs_pkg::MAX_DELIM_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [dcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dcs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [7:0]                     s_data_byte,
    input  logic                           s_frame_last,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [7:0]                     m_out_byte,
    input  logic                           m_frame_done,
    input  logic                           m_run_last,
    output int unsigned                    fail_count,
    output int unsigned                    pending_count,
    output int unsigned                    checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_done;
        logic       run_last;
    } stuffed_byte_t;

    // stuffed bytes still owed by the block, oldest first
    stuffed_byte_t                  expected_q[$];

    // shadow of the block state and registers
    logic [7:0]                     win [MAX_DELIM];
    int unsigned                    win_cnt;
    bit                             framing;
    logic [3:0]                     dlen_reg;
    logic [dcs_pkg::CFG_DATA_W-1:0] dbytes_reg;

    int unsigned                    n_fail;
    int unsigned                    n_checked;
    stuffed_byte_t                  want;

    initial begin
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
        n_fail        = 0;
        n_checked     = 0;
        win_cnt       = 0;
        framing       = 1'b0;
        dlen_reg      = dcs_pkg::DELIM_LENGTH_RST;
        dbytes_reg    = dcs_pkg::DELIM_BYTES_RST;
    end

    // length register saturates into 1..MAX_DELIM
    function automatic int unsigned active_len();
        if (dlen_reg == 4'd0) begin
            return 1;
        end
        if (dlen_reg > MAX_DELIM) begin
            return MAX_DELIM;
        end
        return dlen_reg;
    endfunction

    function automatic logic [7:0] delim_at(int unsigned k);
        return dbytes_reg[8*k +: 8];
    endfunction

    function automatic void put(logic [7:0] b, logic done);
        stuffed_byte_t item;
        item.out_byte   = b;
        item.frame_done = done;
        item.run_last   = 1'b0;
        expected_q.insert(expected_q.size(), item);
    endfunction

    function automatic void put_delim(int unsigned len, bit closing);
        for (int unsigned k = 0; k < len; k++) begin
            put(delim_at(k), closing && (k + 1 == len));
        end
    endfunction

    function automatic void drop_oldest(int unsigned n);
        if (n >= win_cnt) begin
            win_cnt = 0;
        end else begin
            for (int unsigned i = 0; i + n < win_cnt; i++) begin
                win[i] = win[i + n];
            end
            win_cnt = win_cnt - n;
        end
    endfunction

    // stuffed bytes caused by one input byte
    function automatic void stuff_input(logic [7:0] data_in, logic last_in);
        int unsigned len;
        int unsigned first;
        bit          hit;
        len   = active_len();
        first = expected_q.size();

        // frame opener
        if (!framing) begin
            put_delim(len, 1'b0);
            framing = 1'b1;
            win_cnt = 0;
        end

        if (win_cnt < MAX_DELIM) begin
            win[win_cnt] = data_in;
            win_cnt++;
        end

        // compare the window head while it is long enough
        while (win_cnt >= len) begin
            hit = 1'b1;
            for (int unsigned k = 0; k < len; k++) begin
                if (win[k] != delim_at(k)) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                put_delim(len, 1'b0);
                put_delim(len, 1'b0);
                drop_oldest(len);
            end else begin
                put(win[0], 1'b0);
                drop_oldest(1);
            end
        end

        // short tail passes through, then the frame closer
        if (last_in) begin
            for (int unsigned k = 0; k < win_cnt; k++) begin
                put(win[k], 1'b0);
            end
            win_cnt = 0;
            put_delim(len, 1'b1);
            framing = 1'b0;
        end

        if (expected_q.size() > first) begin
            expected_q[expected_q.size() - 1].run_last = 1'b1;
        end
    endfunction

    // compare, then follow register writes and input requests
    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_q.delete();
            win_cnt    = 0;
            framing    = 1'b0;
            dlen_reg   = dcs_pkg::DELIM_LENGTH_RST;
            dbytes_reg = dcs_pkg::DELIM_BYTES_RST;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected stuffed byte %02h", m_out_byte);
                    n_fail++;
                end else begin
                    want = expected_q.pop_front();
                    n_checked++;
                    if (m_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %02h, got %02h", want.out_byte, m_out_byte);
                        n_fail++;
                    end
                    if (m_frame_done !== want.frame_done) begin
                        $error("frame_done: expected %0b, got %0b",
                               want.frame_done, m_frame_done);
                        n_fail++;
                    end
                    if (m_run_last !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b", want.run_last, m_run_last);
                        n_fail++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    dcs_pkg::REG_DELIM_LENGTH: begin
                        dlen_reg = cfg_data[3:0];
                    end
                    dcs_pkg::REG_DELIM_BYTES: begin
                        dbytes_reg = cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                stuff_input(s_data_byte, s_frame_last);
            end
        end
        fail_count    <= n_fail;
        pending_count <= expected_q.size();
        checked_count <= n_checked;
    end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives framed byte streams and register writes into the delimiter
// character stuffer under varying idle patterns and a long output stall;
// the stream checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          IDX_W        = dcs_pkg::CFG_IDX_W;
    localparam int          DATA_W       = dcs_pkg::CFG_DATA_W;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          DRAIN_LIMIT  = 200000;
    localparam int          NUM_PHASES   = 12;
    localparam int          PHASE_ITEMS  = 33;
    localparam logic [IDX_W-1:0] REG_IDX_TOP = '1;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index    = '0;
    logic [DATA_W-1:0]     cfg_data     = '0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_data_byte  = '0;
    logic                  s_frame_last = 1'b0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [7:0]            m_out_byte;
    logic                  m_frame_done;
    logic                  m_run_last;

    int unsigned           fail_count;
    int unsigned           pending_count;
    int unsigned           checked_count;

    // stimulus control
    int unsigned           send_idle = 34;
    int unsigned           recv_idle = 80;
    bit                    hold_req  = 1'b0;
    int unsigned           bytes_sent;
    int unsigned           regs_written;
    int unsigned           frame_left;
    logic [3:0]            cur_len   = dcs_pkg::DELIM_LENGTH_RST;
    logic [DATA_W-1:0]     cur_delim = dcs_pkg::DELIM_BYTES_RST;
    logic [7:0]            source_q[$];

    delimiter_char_stuffer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_frame_last (s_frame_last),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_frame_done (m_frame_done),
        .m_run_last   (m_run_last)
    );

    stuffed_stream_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_frame_last  (s_frame_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_byte    (m_out_byte),
        .m_frame_done  (m_frame_done),
        .m_run_last    (m_run_last),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    always #5 aclk = ~aclk;

    // receiver: random backpressure, long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // run guard
    initial begin
        #30ms;
        $display("tb: failure");
        $finish;
    end

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == dcs_pkg::REG_DELIM_LENGTH) begin
            cur_len = value[3:0];
        end else if (idx == dcs_pkg::REG_DELIM_BYTES) begin
            cur_delim = value;
        end
        regs_written++;
        @(posedge aclk);
    endtask

    // one input request, with a random gap in front
    task automatic push_byte(logic [7:0] b, logic last);
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_frame_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // let every owed byte arrive and the sequencer go quiet
    task automatic wait_for_idle();
        int unsigned n;
        n = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0 && n < DRAIN_LIMIT) begin
            @(posedge aclk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // framed random bytes, biased toward delimiter runs and prefixes
    task automatic run_phase(int unsigned n_items);
        logic [7:0]  b;
        int unsigned eff;
        int unsigned pick;
        int unsigned cut;
        source_q.delete();
        eff = (cur_len == 4'd0) ? 1 : ((cur_len > dcs_pkg::MAX_DELIM_DEF)
                                       ? dcs_pkg::MAX_DELIM_DEF : cur_len);
        repeat (n_items) begin
            if (frame_left == 0) begin
                frame_left = ($urandom_range(7) == 0) ? $urandom_range(11, 30)
                                                      : $urandom_range(1, 10);
            end
            if (source_q.size() == 0) begin
                pick = $urandom_range(9);
                if (pick < 3) begin
                    for (int unsigned k = 0; k < eff; k++) begin
                        source_q.insert(source_q.size(), cur_delim[8*k +: 8]);
                    end
                end else if (pick == 3) begin
                    cut = $urandom_range(eff);
                    for (int unsigned k = 0; k < cut; k++) begin
                        source_q.insert(source_q.size(), cur_delim[8*k +: 8]);
                    end
                    source_q.insert(source_q.size(), 8'($urandom));
                end else if (pick < 6) begin
                    cut = $urandom_range(eff - 1);
                    source_q.insert(source_q.size(), cur_delim[8*cut +: 8]);
                end else begin
                    source_q.insert(source_q.size(), 8'($urandom));
                end
            end
            b = source_q.pop_front();
            frame_left--;
            push_byte(b, frame_left == 0);
        end
    endtask

    // main sequence
    initial begin
        logic [3:0]        len_val;
        logic [DATA_W-1:0] delim_val;
        bytes_sent   = 0;
        regs_written = 0;
        frame_left   = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset delimiter: in-band match on a one-byte frame, field extremes
        push_byte(8'h7e, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h7e, 1'b0);
        push_byte(8'hff, 1'b1);

        // three-byte delimiter: full match, then a short tail that never matches
        wait_for_idle();
        write_reg(dcs_pkg::REG_DELIM_LENGTH, 64'd3);
        write_reg(dcs_pkg::REG_DELIM_BYTES, 64'h0000_0000_00c3_b2a1);
        write_reg(REG_IDX_TOP, '1);
        push_byte(8'ha1, 1'b0);
        push_byte(8'hb2, 1'b0);
        push_byte(8'hc3, 1'b0);
        push_byte(8'ha1, 1'b0);
        push_byte(8'hb2, 1'b1);

        // longest delimiter, matched whole
        wait_for_idle();
        write_reg(dcs_pkg::REG_DELIM_LENGTH, 64'd8);
        write_reg(dcs_pkg::REG_DELIM_BYTES, 64'h8877_6655_4433_2211);
        for (int k = 0; k < 8; k++) begin
            push_byte(8'((k + 1) * 8'h11), 1'b0);
        end
        push_byte(8'h5a, 1'b1);

        // shorten the delimiter while the window is nearly full
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'h04, 1'b0);
        push_byte(8'h05, 1'b0);
        push_byte(8'h06, 1'b0);
        wait_for_idle();
        write_reg(dcs_pkg::REG_DELIM_LENGTH, 64'd2);
        write_reg(dcs_pkg::REG_DELIM_BYTES, 64'h0302);
        push_byte(8'h07, 1'b0);

        // new delimiter bytes mid-frame, used by the closer too
        wait_for_idle();
        write_reg(dcs_pkg::REG_DELIM_BYTES, 64'haaaa);
        push_byte(8'haa, 1'b1);

        // random phases with a fresh register setting each
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_for_idle();
            if (phase < 4) begin
                send_idle = 34;
                recv_idle = 80;
            end else if (phase < 8) begin
                send_idle = 80;
                recv_idle = 34;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            case (phase)
                0: len_val = 4'd1;
                1: len_val = 4'd8;
                2: len_val = 4'd0;
                3: len_val = 4'd15;
                default: begin
                    len_val = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                       : 4'($urandom_range(1, 8));
                end
            endcase
            case (phase)
                4: delim_val = '0;
                5: delim_val = '1;
                default: delim_val = {$urandom, $urandom};
            endcase
            write_reg(dcs_pkg::REG_DELIM_LENGTH,
                      ({$urandom, $urandom} & ~64'hf) | 64'(len_val));
            write_reg(dcs_pkg::REG_DELIM_BYTES, delim_val);
            if ($urandom_range(2) == 0) begin
                write_reg(IDX_W'($urandom_range(dcs_pkg::REG_DELIM_BYTES + 1, REG_IDX_TOP)),
                          {$urandom, $urandom});
            end
            // output stalls for a long stretch while input keeps coming
            if (phase == 1) begin
                hold_req = 1'b1;
            end
            run_phase(PHASE_ITEMS);
        end

        send_idle = 0;
        recv_idle = 0;
        wait_for_idle();

        $display("summary: %0d input bytes, %0d stuffed bytes checked, %0d register writes",
                 bytes_sent, checked_count, regs_written);
        $display("summary: lengths 0 to 15, mid-frame register changes, %0d-cycle output stall",
                 HOLD_CYCLES);
        if (pending_count != 0) begin
            $error("%0d expected stuffed bytes never arrived", pending_count);
        end
        if (fail_count == 0 && pending_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
